/* rtl/text_console_cursor_controller_top_assert.svh */
// Assertion macros shared by the console controller modules.
// Each module that uses them has ports named i_clk and i_rst_n.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_TOP_ASSERT_SVH

// A property checked at every clock edge outside reset.
`define TCC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define TCC_ASSERT_NEXT(name, ante, cons, msg) \
    `TCC_ASSERT(name, (ante) |=> (cons), msg)

`endif

/* rtl/tcc_pkg.sv */
package tcc_pkg;

    localparam int GLYPH_HEIGHT = 16;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE = 8'd126;

    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] ACT_DRAW = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_COPY = 2'd3;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_LINES = 2'd2;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS = 7'd25;
    localparam logic [11:0] RST_LINES = 12'd400;

    localparam logic [7:0] CHR_BS = 8'h08;
    localparam logic [7:0] CHR_TAB = 8'h09;
    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_QUESTION = 8'h3F;

    localparam logic [8:0] TAB_MASK = 9'h1F8;
    localparam logic [7:0] DIRTY_EMPTY_LOW = 8'hFF;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows;
        logic [11:0] lines;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] cell_col;
        logic [6:0] cell_row;
        logic [7:0] glyph_code;
        logic [11:0] first_line;
        logic [11:0] end_line;
        logic last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result slot1;
        t_result slot0;
    } t_emit;

endpackage

/* rtl/tcc_cmd_if.sv */
interface tcc_cmd_if;
    logic valid;
    logic ready;
    logic [1:0] command;
    logic [7:0] char_code;

    modport source(output valid, output command, output char_code, input ready);
    modport sink(input valid, input command, input char_code, output ready);
endinterface

/* rtl/tcc_res_if.sv */
interface tcc_res_if;
    logic valid;
    logic ready;
    logic [1:0] action;
    logic [7:0] cell_col;
    logic [6:0] cell_row;
    logic [7:0] glyph_code;
    logic [11:0] first_line;
    logic [11:0] end_line;
    logic last;

    modport source(
        output valid, output action, output cell_col, output cell_row,
        output glyph_code, output first_line, output end_line, output last,
        input ready
    );
    modport sink(
        input valid, input action, input cell_col, input cell_row,
        input glyph_code, input first_line, input end_line, input last,
        output ready
    );
endinterface

/* rtl/tcc_engine.sv */
`include "text_console_cursor_controller_top_assert.svh"

module tcc_engine import tcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_code,
    input  t_cfg       i_cfg,
    output t_emit      o_emit
);

    logic [7:0] r_col, n_col;
    logic [6:0] r_row, n_row;
    logic [7:0] r_low, n_low;
    logic [6:0] r_high, n_high;

    function automatic t_result copy_result(logic [7:0] low, logic [6:0] high,
                                            logic [11:0] lines);
        t_result r;
        logic [12:0] y0;
        logic [12:0] y1;
        r = '0;
        r.action = ACT_COPY;
        y0 = 13'(low) * 13'(GLYPH_HEIGHT);
        y1 = (13'(high) + 13'd1) * 13'(GLYPH_HEIGHT);
        if (y1 > {1'b0, lines}) begin
            y1 = {1'b0, lines};
        end
        if (y0 > y1) begin
            y0 = y1;
        end
        r.first_line = y0[11:0];
        r.end_line = y1[11:0];
        return r;
    endfunction

    function automatic t_result draw_result(logic [7:0] col, logic [6:0] row,
                                            logic [7:0] code);
        t_result r;
        r = '0;
        r.action = ACT_DRAW;
        r.cell_col = col;
        r.cell_row = row;
        if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) begin
            r.glyph_code = CHR_QUESTION;
        end else begin
            r.glyph_code = code;
        end
        return r;
    endfunction

    logic [7:0] cols_eff;
    logic [6:0] rows_eff;
    logic [7:0] row_inc;
    logic [8:0] col_inc;
    logic [8:0] tab_stop;
    logic [7:0] col_back;
    logic       do_draw;
    logic       do_newline;
    logic [7:0] draw_col;
    logic [7:0] draw_code;
    t_result    scroll_res;
    t_result    clear_res;

    assign cols_eff = (i_cfg.columns == 8'd0) ? 8'd1 : i_cfg.columns;
    assign rows_eff = (i_cfg.rows == 7'd0) ? 7'd1 : i_cfg.rows;
    assign row_inc = {1'b0, r_row} + 8'd1;
    assign col_inc = {1'b0, r_col} + 9'd1;
    assign tab_stop = ({1'b0, r_col} + 9'd8) & TAB_MASK;
    assign col_back = (r_col != 8'd0) ? r_col - 8'd1 : r_col;

    always_comb begin
        scroll_res = '0;
        scroll_res.action = ACT_SCROLL;
        clear_res = '0;
        clear_res.action = ACT_CLEAR;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_low = r_low;
        n_high = r_high;
        o_emit = '0;
        do_draw = 1'b0;
        do_newline = 1'b0;
        draw_col = r_col;
        draw_code = i_char_code;

        unique case (i_command)
            CMD_PUT: begin
                unique case (i_char_code)
                    CHR_LF: begin
                        do_newline = 1'b1;
                    end
                    CHR_CR: begin
                        n_col = 8'd0;
                    end
                    CHR_TAB: begin
                        if (tab_stop >= {1'b0, cols_eff}) begin
                            do_newline = 1'b1;
                        end else begin
                            n_col = tab_stop[7:0];
                        end
                    end
                    CHR_BS: begin
                        n_col = col_back;
                        do_draw = 1'b1;
                        draw_col = col_back;
                        draw_code = CHR_SPACE;
                    end
                    default: begin
                        do_draw = 1'b1;
                        if (col_inc >= {1'b0, cols_eff}) begin
                            do_newline = 1'b1;
                        end else begin
                            n_col = col_inc[7:0];
                        end
                    end
                endcase

                if (do_draw) begin
                    o_emit.slot0 = draw_result(draw_col, r_row, draw_code);
                    o_emit.count = 2'd1;
                    if ({1'b0, r_row} < r_low) begin
                        n_low = {1'b0, r_row};
                    end
                    if (r_row > r_high) begin
                        n_high = r_row;
                    end
                end

                if (do_newline) begin
                    n_col = 8'd0;
                    if (row_inc >= {1'b0, rows_eff}) begin
                        n_row = rows_eff - 7'd1;
                        n_low = 8'd0;
                        n_high = rows_eff - 7'd1;
                        if (do_draw) begin
                            o_emit.slot1 = scroll_res;
                            o_emit.count = 2'd2;
                        end else begin
                            o_emit.slot0 = scroll_res;
                            o_emit.count = 2'd1;
                        end
                    end else begin
                        n_row = row_inc[6:0];
                    end
                end
            end
            CMD_FLUSH: begin
                if (r_low <= {1'b0, r_high}) begin
                    o_emit.slot0 = copy_result(r_low, r_high, i_cfg.lines);
                    o_emit.count = 2'd1;
                    n_low = DIRTY_EMPTY_LOW;
                    n_high = 7'd0;
                end
            end
            CMD_CLEAR: begin
                n_col = 8'd0;
                n_row = 7'd0;
                o_emit.slot0 = clear_res;
                o_emit.slot1 = copy_result(8'd0, rows_eff - 7'd1, i_cfg.lines);
                o_emit.count = 2'd2;
                n_low = DIRTY_EMPTY_LOW;
                n_high = 7'd0;
            end
            default: begin
            end
        endcase

        if (o_emit.count == 2'd1) begin
            o_emit.slot0.last = 1'b1;
        end
        if (o_emit.count == 2'd2) begin
            o_emit.slot1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 7'd0;
            r_low <= DIRTY_EMPTY_LOW;
            r_high <= 7'd0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_low <= n_low;
            r_high <= n_high;
        end
    end

    `TCC_ASSERT(a_reserved_silent, (i_accept && i_command == CMD_RESERVED) |-> (o_emit.count == 2'd0), "reserved command produced a result")
    `TCC_ASSERT(a_flush_twice_empty, (i_accept && i_command == CMD_FLUSH) ##1 (i_accept && i_command == CMD_FLUSH) |-> (o_emit.count == 2'd0), "second flush found a dirty range")
    `TCC_ASSERT_NEXT(a_clear_homes_cursor, i_accept && i_command == CMD_CLEAR, r_col == 8'd0 && r_row == 7'd0 && r_low == DIRTY_EMPTY_LOW, "clear left cursor or dirty range set")

endmodule

/* rtl/tcc_out_fifo.sv */
`include "text_console_cursor_controller_top_assert.svh"

module tcc_out_fifo import tcc_pkg::*; #(
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_emit,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            pop_ok;

    assign pop_ok = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt <= CW'(DEPTH - 2));
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr] <= i_emit.slot0;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_emit.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= r_wr + AW'(i_emit.count);
            r_rd <= r_rd + AW'(pop_ok);
            r_cnt <= r_cnt + CW'(i_emit.count) - CW'(pop_ok);
        end
    end

    `TCC_ASSERT(a_no_overflow, r_cnt <= CW'(DEPTH), "result queue holds more than its depth")
    `TCC_ASSERT(a_push_has_room, (i_emit.count != 2'd0) |-> o_space, "results pushed without room")
    `TCC_ASSERT_NEXT(a_count_tracks, 1'b1, r_cnt == $past(r_cnt) + CW'($past(i_emit.count)) - CW'($past(pop_ok)), "queue count lost a transaction")

endmodule

/* rtl/text_console_cursor_controller_top.sv */
// Text console cursor and scroll controller.
// Command channel i_cmd: each transaction carries a command (put character,
// flush dirty rows, clear screen) and a character byte. Result channel o_res:
// each transaction carries one draw, scroll, clear or copy command, with last
// set on the final result of a command. Commands may cause zero, one or two
// results. Configuration (columns, rows, screen lines) is written through
// i_cfg_we, i_cfg_idx and i_cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. The results
// of an accepted command are written into the result queue and are offered
// once earlier results have drained. A command is accepted in every cycle
// while the result queue has room for two results; the queue drains one
// result per cycle while o_res.ready is high.
// Reset clears the cursor to the top left, empties the dirty range, empties
// the result queue, holds i_cmd.ready low and loads 80 columns, 25 rows and
// 400 lines.
// When the receiver holds o_res.ready low, results wait in the queue and
// i_cmd.ready falls once fewer than two entries are free.
module text_console_cursor_controller_top import tcc_pkg::*; #(
    parameter int OUT_DEPTH_P = OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    tcc_cmd_if.sink     i_cmd,
    tcc_res_if.source   o_res
);

    t_cfg    r_cfg;
    t_emit   emit;
    t_result head;
    logic    space;
    logic    accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns <= RST_COLUMNS;
            r_cfg.rows <= RST_ROWS;
            r_cfg.lines <= RST_LINES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLUMNS: r_cfg.columns <= i_cfg_data[7:0];
                CFG_ROWS:    r_cfg.rows <= i_cfg_data[6:0];
                CFG_LINES:   r_cfg.lines <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_cmd.ready = space && i_rst_n;
    assign accept = i_cmd.valid && space && i_rst_n;

    tcc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_cmd.command),
        .i_char_code (i_cmd.char_code),
        .i_cfg       (r_cfg),
        .o_emit      (emit)
    );

    t_emit push;

    always_comb begin
        push = emit;
        if (!accept) begin
            push.count = 2'd0;
        end
    end

    tcc_out_fifo #(
        .DEPTH (OUT_DEPTH_P)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (push),
        .o_space (space),
        .o_valid (o_res.valid),
        .i_pop   (o_res.ready),
        .o_data  (head)
    );

    assign o_res.action = head.action;
    assign o_res.cell_col = head.cell_col;
    assign o_res.cell_row = head.cell_row;
    assign o_res.glyph_code = head.glyph_code;
    assign o_res.first_line = head.first_line;
    assign o_res.end_line = head.end_line;
    assign o_res.last = head.last;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PCT = 17;

    typedef enum int {RX_RANDOM, RX_STEADY, RX_HOLD} t_rx_mode;

    // Tracks the cursor, the dirty rows and the settings, and keeps the results
    // that accepted commands are still owed.
    class console_scoreboard;
        t_result owed_q[$];
        int errors;
        int unsigned cols;
        int unsigned rows;
        int unsigned lines;
        int unsigned cur_col;
        int unsigned cur_row;
        int unsigned dirty_lo;
        int unsigned dirty_hi;

        function new();
            errors = 0;
            cols = RST_COLUMNS;
            rows = RST_ROWS;
            lines = RST_LINES;
            cur_col = 0;
            cur_row = 0;
            dirty_lo = DIRTY_EMPTY_LOW;
            dirty_hi = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] value);
            case (idx)
                CFG_COLUMNS: cols = value[7:0];
                CFG_ROWS: rows = value[6:0];
                CFG_LINES: lines = value;
                default: ;
            endcase
        endfunction

        function int unsigned eff_cols();
            return (cols == 0) ? 1 : cols;
        endfunction

        function int unsigned eff_rows();
            return (rows == 0) ? 1 : rows;
        endfunction

        function void owe(logic [1:0] act, int unsigned col, int unsigned row,
                          int unsigned glyph, int unsigned y_first, int unsigned y_end);
            t_result r;
            r.action = act;
            r.cell_col = col[7:0];
            r.cell_row = row[6:0];
            r.glyph_code = glyph[7:0];
            r.first_line = y_first[11:0];
            r.end_line = y_end[11:0];
            r.last = 1'b0;
            owed_q.push_back(r);
        endfunction

        function void mark_all_dirty();
            dirty_lo = 0;
            dirty_hi = (eff_rows() - 1) & 'h7F;
        endfunction

        function void line_feed();
            int unsigned nxt;
            nxt = cur_row + 1;
            cur_col = 0;
            if (nxt >= eff_rows()) begin
                cur_row = (eff_rows() - 1) & 'h7F;
                mark_all_dirty();
                owe(ACT_SCROLL, 0, 0, 0, 0, 0);
            end else begin
                cur_row = nxt & 'h7F;
            end
        endfunction

        function void draw_glyph(logic [7:0] ch);
            logic [7:0] glyph;
            glyph = (ch < FIRST_PRINTABLE || ch > LAST_PRINTABLE) ? CHR_QUESTION : ch;
            owe(ACT_DRAW, cur_col, cur_row, glyph, 0, 0);
            if (cur_row < dirty_lo) dirty_lo = cur_row;
            if (cur_row > dirty_hi) dirty_hi = cur_row;
        endfunction

        function void flush_rows();
            int unsigned y0;
            int unsigned y1;
            if (dirty_lo > dirty_hi) return;
            y0 = dirty_lo * GLYPH_HEIGHT;
            y1 = (dirty_hi + 1) * GLYPH_HEIGHT;
            if (y1 > lines) y1 = lines;
            if (y0 > y1) y0 = y1;
            owe(ACT_COPY, 0, 0, 0, y0, y1);
            dirty_lo = DIRTY_EMPTY_LOW;
            dirty_hi = 0;
        endfunction

        function void put_char(logic [7:0] ch);
            int unsigned nxt;
            if (ch == CHR_LF) begin
                line_feed();
            end else if (ch == CHR_CR) begin
                cur_col = 0;
            end else if (ch == CHR_TAB) begin
                nxt = (cur_col + 8) & TAB_MASK;
                if (nxt >= eff_cols()) line_feed();
                else cur_col = nxt & 'hFF;
            end else if (ch == CHR_BS) begin
                if (cur_col > 0) cur_col = cur_col - 1;
                draw_glyph(CHR_SPACE);
            end else begin
                draw_glyph(ch);
                nxt = cur_col + 1;
                if (nxt >= eff_cols()) line_feed();
                else cur_col = nxt & 'hFF;
            end
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] ch);
            int n0;
            n0 = owed_q.size();
            case (cmd)
                CMD_PUT: put_char(ch);
                CMD_FLUSH: flush_rows();
                CMD_CLEAR: begin
                    cur_col = 0;
                    cur_row = 0;
                    mark_all_dirty();
                    owe(ACT_CLEAR, 0, 0, 0, 0, 0);
                    flush_rows();
                end
                default: ;
            endcase
            if (owed_q.size() > n0) owed_q[owed_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                errors++;
                $display({"%0t: unexpected result action=%0d col=%0d row=%0d",
                          " glyph=%0d first=%0d end=%0d last=%0d"},
                         $time, got.action, got.cell_col, got.cell_row, got.glyph_code,
                         got.first_line, got.end_line, got.last);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                errors++;
                $display({"%0t: mismatch expected action=%0d col=%0d row=%0d",
                          " glyph=%0d first=%0d end=%0d last=%0d"},
                         $time, want.action, want.cell_col, want.cell_row, want.glyph_code,
                         want.first_line, want.end_line, want.last);
                $display({"%0t:          actual   action=%0d col=%0d row=%0d",
                          " glyph=%0d first=%0d end=%0d last=%0d"},
                         $time, got.action, got.cell_col, got.cell_row, got.glyph_code,
                         got.first_line, got.end_line, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [11:0] i_cfg_data;

    tcc_cmd_if cmd_if();
    tcc_res_if res_if();

    console_scoreboard board = new();
    t_rx_mode rx_mode;
    int hold_count;
    int cycle_count = 0;
    bit tx_idle_on;

    text_console_cursor_controller_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd(cmd_if),
        .o_res(res_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_mode == RX_HOLD) begin
            if (hold_count < HOLD_CYCLES) begin
                res_if.ready <= 1'b0;
                hold_count <= hold_count + 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end else begin
            hold_count <= 0;
            if (rx_mode == RX_STEADY) res_if.ready <= 1'b1;
            else res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                board.note_command(cmd_if.command, cmd_if.char_code);
            end
            if (res_if.valid && res_if.ready) begin
                got.action = res_if.action;
                got.cell_col = res_if.cell_col;
                got.cell_row = res_if.cell_row;
                got.glyph_code = res_if.glyph_code;
                got.first_line = res_if.first_line;
                got.end_line = res_if.end_line;
                got.last = res_if.last;
                board.check_result(got);
            end
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] ch);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.char_code <= ch;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] cols, input logic [6:0] rows,
                                input logic [11:0] lines);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COLUMNS;
        i_cfg_data <= {4'd0, cols};
        @(posedge i_clk);
        board.set_reg(CFG_COLUMNS, {4'd0, cols});
        i_cfg_idx <= CFG_ROWS;
        i_cfg_data <= {5'd0, rows};
        @(posedge i_clk);
        board.set_reg(CFG_ROWS, {5'd0, rows});
        i_cfg_idx <= CFG_LINES;
        i_cfg_data <= lines;
        @(posedge i_clk);
        board.set_reg(CFG_LINES, lines);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
        if (roll < 65) return CHR_LF;
        if (roll < 70) return CHR_CR;
        if (roll < 78) return CHR_TAB;
        if (roll < 86) return CHR_BS;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random(input int count);
        int unsigned roll;
        logic [1:0] cmd;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 84) cmd = CMD_PUT;
            else if (roll < 92) cmd = CMD_FLUSH;
            else if (roll < 96) cmd = CMD_CLEAR;
            else cmd = CMD_RESERVED;
            send_cmd(cmd, pick_char());
        end
    endtask

    task automatic run_phase(input logic [7:0] cols, input logic [6:0] rows,
                             input logic [11:0] lines, input int count);
        drain();
        write_config(cols, rows, lines);
        send_random(count);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_COLUMNS;
        i_cfg_data <= 12'd0;
        cmd_if.valid <= 1'b0;
        cmd_if.command <= CMD_PUT;
        cmd_if.char_code <= 8'd0;
        rx_mode <= RX_RANDOM;
        tx_idle_on = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(CMD_PUT, 8'h41);
        send_cmd(CMD_PUT, 8'h00);
        send_cmd(CMD_PUT, 8'h1F);
        send_cmd(CMD_PUT, FIRST_PRINTABLE);
        send_cmd(CMD_PUT, LAST_PRINTABLE);
        send_cmd(CMD_PUT, 8'h7F);
        send_cmd(CMD_PUT, 8'hFF);
        send_cmd(CMD_PUT, CHR_TAB);
        send_cmd(CMD_PUT, CHR_BS);
        send_cmd(CMD_PUT, CHR_CR);
        send_cmd(CMD_PUT, CHR_BS);
        send_cmd(CMD_PUT, CHR_LF);
        send_cmd(CMD_FLUSH, 8'h00);
        send_cmd(CMD_FLUSH, 8'hFF);
        send_cmd(CMD_RESERVED, 8'hFF);
        send_cmd(CMD_RESERVED, 8'h41);
        send_cmd(CMD_CLEAR, 8'h00);
        send_cmd(CMD_PUT, 8'h7A);
        send_cmd(CMD_PUT, CHR_TAB);
        send_cmd(CMD_FLUSH, 8'h00);
        send_random(150);

        run_phase(8'd4, 7'd3, 12'd4095, 120);
        run_phase(8'd255, 7'd127, 12'd4095, 100);
        run_phase(8'd0, 7'd0, 12'd0, 40);
        run_phase(8'd1, 7'd1, 12'd1, 40);

        // A long stretch with both sides always active.
        drain();
        write_config(8'd13, 7'd5, 12'd50);
        tx_idle_on = 1'b0;
        rx_mode <= RX_STEADY;
        send_random(120);

        // The receiver stalls while commands keep coming, so the block backs up.
        drain();
        write_config(8'd20, 7'd6, 12'd200);
        rx_mode <= RX_HOLD;
        for (int i = 0; i < 40; i++) begin
            send_cmd(CMD_PUT, 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE)));
        end
        rx_mode <= RX_RANDOM;
        tx_idle_on = 1'b1;
        send_random(60);

        run_phase(RST_COLUMNS, RST_ROWS, RST_LINES, 120);
        run_phase(8'd7, 7'd127, 12'd4095, 100);
        run_phase(8'd9, 7'd2, 12'd20, 60);

        drain();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
